// File: src/indexed_array_list_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed array list engine
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication.
`define IALE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IALE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/iale_pkg.sv
// ----------------------------------------------------------------------------
// iale_pkg
// Types and codes shared by the list engine, its cells and its select tree.
// ----------------------------------------------------------------------------
package iale_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 9;
  localparam int IDX_W  = 8;
  localparam int LEN_W  = 9;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OP_W-1:0] OP_PRED   = 3'd4;
  localparam logic [OP_W-1:0] OP_SUCC   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [ST_W-1:0] ST_NONEIGH  = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]          req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] result_value;
    logic [IDX_W-1:0]         result_index;
    logic [LEN_W-1:0]         list_length;
  } rsp_t;

  // What each cell offers to the select tree.
  typedef enum logic [1:0] {
    LEAF_SELECT,
    LEAF_MATCH,
    LEAF_PRED,
    LEAF_SUCC
  } leaf_mode_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    leaf_mode_t        mode;
    logic              ins_en;
    logic              del_en;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] key;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

endpackage

// File: src/iale_cell.sv
// ----------------------------------------------------------------------------
// iale_cell
// One list slot: holds a word, shifts with its neighbors, and offers a leaf
// (hit flag and value) to the select tree.
// ----------------------------------------------------------------------------
module iale_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 9
) (
  input  logic                         clk,
  input  iale_pkg::cell_ctl_t          ctl,
  input  logic [CW-1:0]                count,
  input  logic [iale_pkg::DATA_W-1:0]  prev_word,
  input  logic [iale_pkg::DATA_W-1:0]  next_word,
  output logic [iale_pkg::DATA_W-1:0]  word,
  output logic                         leaf_hit,
  output logic [iale_pkg::DATA_W-1:0]  leaf_val
);

  localparam int CMPW = (CW > iale_pkg::POS_W) ? CW : iale_pkg::POS_W;

  logic [iale_pkg::DATA_W-1:0] word_next;
  logic [CMPW-1:0]             my_idx;
  logic [CMPW-1:0]             pos_ext;
  logic                        in_list;

  assign my_idx  = CMPW'(INDEX);
  assign pos_ext = CMPW'(ctl.position);
  assign in_list = my_idx < CMPW'(count);

  always_comb begin
    word_next = word;
    if (ctl.ins_en) begin
      if (my_idx > pos_ext) begin
        word_next = prev_word;
      end else if (my_idx == pos_ext) begin
        word_next = ctl.key;
      end
    end else if (ctl.del_en) begin
      if (my_idx >= pos_ext) begin
        word_next = next_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  always_comb begin
    unique case (ctl.mode)
      iale_pkg::LEAF_SELECT: begin
        leaf_hit = (my_idx == pos_ext);
        leaf_val = word;
      end
      iale_pkg::LEAF_MATCH: begin
        leaf_hit = in_list && (word == ctl.key);
        leaf_val = word;
      end
      iale_pkg::LEAF_PRED: begin
        leaf_hit = in_list && (word == ctl.key);
        leaf_val = prev_word;
      end
      iale_pkg::LEAF_SUCC: begin
        leaf_hit = in_list && (word == ctl.key);
        leaf_val = next_word;
      end
      default: begin
        leaf_hit = 1'b0;
        leaf_val = word;
      end
    endcase
  end

endmodule

// File: src/iale_tree.sv
// ----------------------------------------------------------------------------
// iale_tree
// Registered priority tree: returns the lowest-index hit among the leaves.
// One register level per tree level, leaves registered too.
// ----------------------------------------------------------------------------
module iale_tree #(
  parameter int N = 256
) (
  input  logic                                 clk,
  input  logic [N-1:0]                         leaf_hit,
  input  logic [iale_pkg::DATA_W-1:0]          leaf_val [N],
  output logic                                 root_hit,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] root_idx,
  output logic [iale_pkg::DATA_W-1:0]          root_val
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
  localparam int TREE_N = 1 << LEVELS;
  localparam int IW     = LEVELS;

  // Heap order: node k has children 2k and 2k+1, leaves at TREE_N and up.
  logic                        hit [2*TREE_N];
  logic [IW-1:0]               idx [2*TREE_N];
  logic [iale_pkg::DATA_W-1:0] val [2*TREE_N];

  for (genvar k = 0; k < TREE_N; k++) begin : g_leaf
    if (k < N) begin : g_real
      always_ff @(posedge clk) begin
        hit[TREE_N+k] <= leaf_hit[k];
        idx[TREE_N+k] <= IW'(k);
        val[TREE_N+k] <= leaf_val[k];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        hit[TREE_N+k] <= 1'b0;
        idx[TREE_N+k] <= IW'(k);
        val[TREE_N+k] <= '0;
      end
    end
  end

  for (genvar k = 1; k < TREE_N; k++) begin : g_node
    // Lower indices sit on the left: prefer it.
    always_ff @(posedge clk) begin
      hit[k] <= hit[2*k] | hit[2*k+1];
      idx[k] <= hit[2*k] ? idx[2*k] : idx[2*k+1];
      val[k] <= hit[2*k] ? val[2*k] : val[2*k+1];
    end
  end

  // Slot zero of the heap is never a node.
  always_ff @(posedge clk) begin
    hit[0] <= 1'b0;
    idx[0] <= '0;
    val[0] <= '0;
  end

  assign root_hit = hit[1];
  assign root_idx = idx[1];
  assign root_val = val[1];

endmodule

// File: src/indexed_array_list_engine_top.sv
// Insert, clear and unused codes go from the request register straight to
// the apply state; delete, read, find, predecessor and successor first wait
// in the scan state while the leaves rise through the registered select tree.
// The apply state holds while the response output is stalled, and only one
// request is in work at once: a new one is taken only when the engine is idle.
// Reset (rst, synchronous) empties the list; stored words are left as they are.
// ----------------------------------------------------------------------------
// indexed_array_list_engine_top
// Fixed-capacity ordered list of signed words held in a chain of cells, with
// insert/delete by shifting, and read/search through a registered tree.
// ----------------------------------------------------------------------------
`include "indexed_array_list_engine_top_defines.svh"

module indexed_array_list_engine_top #(
  parameter int LIST_CAPACITY = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  iale_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output iale_pkg::rsp_t  rsp_data
);

  localparam int LEVELS = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int IW     = LEVELS;
  localparam int CW     = $clog2(LIST_CAPACITY + 1);
  localparam int CMPW   = (CW > iale_pkg::POS_W) ? CW : iale_pkg::POS_W;
  localparam int SCW    = $clog2(LEVELS + 1);
  localparam int DW     = iale_pkg::DATA_W;

  iale_pkg::state_t    state, state_next;
  logic [SCW-1:0]      scan_cnt, scan_cnt_next;
  iale_pkg::req_t      req_q;
  logic [CW-1:0]       count, count_next;
  iale_pkg::cell_ctl_t ctl;

  logic [DW-1:0]       word     [LIST_CAPACITY];
  logic [DW-1:0]       leaf_val [LIST_CAPACITY];
  logic [LIST_CAPACITY-1:0] leaf_hit;

  logic                root_hit;
  logic [IW-1:0]       root_idx;
  logic [DW-1:0]       root_val;

  logic                req_fire;
  logic                apply_fire;
  logic                needs_tree;

  logic [iale_pkg::ST_W-1:0]  st;
  logic [DW-1:0]              rval;
  logic [iale_pkg::IDX_W-1:0] ridx;
  logic                       do_ins, do_del, do_clr;
  logic [CMPW-1:0]            pos_ext, cnt_ext, idx_ext;

  // --------------------------------------------------------------------------
  // Cell chain and select tree
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
    logic [DW-1:0] prev_w;
    logic [DW-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = word[i-1];
    end

    if (i == LIST_CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = word[i+1];
    end

    iale_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (word[i]),
      .leaf_hit  (leaf_hit[i]),
      .leaf_val  (leaf_val[i])
    );
  end

  iale_tree #(
    .N (LIST_CAPACITY)
  ) u_tree (
    .clk      (clk),
    .leaf_hit (leaf_hit),
    .leaf_val (leaf_val),
    .root_hit (root_hit),
    .root_idx (root_idx),
    .root_val (root_val)
  );

  // --------------------------------------------------------------------------
  // Request register and control
  // --------------------------------------------------------------------------
  assign req_fire   = req_valid && !req_stall;
  assign apply_fire = (state == iale_pkg::S_APPLY) && (!rsp_valid || !rsp_stall);

  always_comb begin
    unique case (req_data.req_type) inside
      iale_pkg::OP_DELETE, iale_pkg::OP_READ, iale_pkg::OP_FIND,
      iale_pkg::OP_PRED, iale_pkg::OP_SUCC: needs_tree = 1'b1;
      default:                              needs_tree = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= iale_pkg::S_IDLE;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    req_stall     = 1'b1;
    unique case (state)
      iale_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          scan_cnt_next = '0;
          state_next    = needs_tree ? iale_pkg::S_SCAN : iale_pkg::S_APPLY;
        end
      end
      iale_pkg::S_SCAN: begin
        // Wait for the leaves to rise through every tree level.
        scan_cnt_next = scan_cnt + SCW'(1);
        if (scan_cnt == SCW'(LEVELS)) begin
          state_next = iale_pkg::S_APPLY;
        end
      end
      iale_pkg::S_APPLY: begin
        if (apply_fire) begin
          state_next = iale_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = iale_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Status and result
  // --------------------------------------------------------------------------
  assign pos_ext = CMPW'(req_q.position);
  assign cnt_ext = CMPW'(count);
  assign idx_ext = CMPW'(root_idx);

  always_comb begin
    st     = iale_pkg::ST_OK;
    rval   = '0;
    ridx   = '0;
    do_ins = 1'b0;
    do_del = 1'b0;
    do_clr = 1'b0;
    unique case (req_q.req_type) inside
      iale_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          st = iale_pkg::ST_RANGE;
        end else if (count == CW'(LIST_CAPACITY)) begin
          st = iale_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      iale_pkg::OP_DELETE, iale_pkg::OP_READ: begin
        if (count == '0) begin
          st = iale_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          st = iale_pkg::ST_RANGE;
        end else begin
          rval   = root_val;
          do_del = (req_q.req_type == iale_pkg::OP_DELETE);
        end
      end
      iale_pkg::OP_FIND, iale_pkg::OP_PRED, iale_pkg::OP_SUCC: begin
        if (count == '0) begin
          st = iale_pkg::ST_EMPTY;
        end else if (!root_hit) begin
          st = iale_pkg::ST_NOTFOUND;
        end else if (req_q.req_type == iale_pkg::OP_FIND) begin
          ridx = iale_pkg::IDX_W'(root_idx);
        end else if (req_q.req_type == iale_pkg::OP_PRED) begin
          if (root_idx == '0) begin
            st = iale_pkg::ST_NONEIGH;
          end else begin
            rval = root_val;
          end
        end else begin
          if (idx_ext + CMPW'(1) >= cnt_ext) begin
            st = iale_pkg::ST_NONEIGH;
          end else begin
            rval = root_val;
          end
        end
      end
      iale_pkg::OP_CLEAR: begin
        do_clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.position = req_q.position;
    ctl.key      = req_q.data_value;
    ctl.ins_en   = apply_fire && do_ins;
    ctl.del_en   = apply_fire && do_del;
    unique case (req_q.req_type) inside
      iale_pkg::OP_FIND: ctl.mode = iale_pkg::LEAF_MATCH;
      iale_pkg::OP_PRED: ctl.mode = iale_pkg::LEAF_PRED;
      iale_pkg::OP_SUCC: ctl.mode = iale_pkg::LEAF_SUCC;
      default:           ctl.mode = iale_pkg::LEAF_SELECT;
    endcase
  end

  always_comb begin
    count_next = count;
    if (apply_fire) begin
      if (do_ins) begin
        count_next = count + CW'(1);
      end else if (do_del) begin
        count_next = count - CW'(1);
      end else if (do_clr) begin
        count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      rsp_data.status       <= st;
      rsp_data.result_value <= rval;
      rsp_data.result_index <= ridx;
      rsp_data.list_length  <= iale_pkg::LEN_W'(count_next);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `IALE_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, count <= CW'(LIST_CAPACITY), "list length over capacity")
  `IALE_ASSERT_NEXT(a_busy_after_req, clk, rst, req_fire, state != iale_pkg::S_IDLE, "request accepted but engine idle")
  `IALE_ASSERT_NEXT(a_len_only_apply, clk, rst, !apply_fire, $stable(count), "list length changed outside apply")
  `IALE_ASSERT_NEXT(a_insert_grows, clk, rst, apply_fire && do_ins, count == $past(count) + CW'(1), "insert did not grow list")

endmodule

// File: test/tb_indexed_array_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_array_list_engine_top
// Self-checking bench for the list engine. A queue of requests, planned up
// front, feeds a clocked driver. The driver updates a behavioral copy of the
// list on each accepted request and queues the expected response. A clocked
// monitor compares every accepted response field by field. Both sides insert
// random idle and stall bursts, and once the monitor holds off long enough
// for the engine to back up.
// ----------------------------------------------------------------------------
module tb_indexed_array_list_engine_top;

  localparam int LIST_CAPACITY  = 256;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int TAIL_ITEMS     = 150;
  localparam int BACKLOG_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int STUCK_LIMIT    = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [iale_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  iale_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  iale_pkg::rsp_t rsp_data;

  // request plan and expected responses
  iale_pkg::req_t pending[$];
  iale_pkg::rsp_t expected_rsps[$];
  int unsigned planned_len = 0;
  logic signed [iale_pkg::DATA_W-1:0] value_pool[16];

  // behavioral copy of the list
  logic signed [iale_pkg::DATA_W-1:0] list_words[LIST_CAPACITY];
  int unsigned list_len = 0;

  int error_count = 0;
  int checked_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int backlog_hold = 0;
  bit backlog_done = 1'b0;
  logic tail_phase = 1'b0;

  indexed_array_list_engine_top #(
    .LIST_CAPACITY(LIST_CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the list copy and return the response it should give.
  function automatic iale_pkg::rsp_t apply_list_request(input iale_pkg::req_t r);
    iale_pkg::rsp_t o;
    int unsigned hit;
    o = '0;
    case (r.req_type)
      iale_pkg::OP_INSERT: begin
        if (r.position > list_len) begin
          o.status = iale_pkg::ST_RANGE;
        end else if (list_len >= LIST_CAPACITY) begin
          o.status = iale_pkg::ST_FULL;
        end else begin
          for (int unsigned i = list_len; i > r.position; i--)
            list_words[i] = list_words[i-1];
          list_words[r.position] = r.data_value;
          list_len++;
        end
      end
      iale_pkg::OP_DELETE, iale_pkg::OP_READ: begin
        if (list_len == 0) begin
          o.status = iale_pkg::ST_EMPTY;
        end else if (r.position >= list_len) begin
          o.status = iale_pkg::ST_RANGE;
        end else begin
          o.result_value = list_words[r.position];
          if (r.req_type == iale_pkg::OP_DELETE) begin
            for (int unsigned i = r.position + 1; i < list_len; i++)
              list_words[i-1] = list_words[i];
            list_len--;
          end
        end
      end
      iale_pkg::OP_FIND, iale_pkg::OP_PRED, iale_pkg::OP_SUCC: begin
        if (list_len == 0) begin
          o.status = iale_pkg::ST_EMPTY;
        end else begin
          hit = list_len;
          for (int unsigned i = 0; i < list_len; i++) begin
            if (list_words[i] == r.data_value) begin
              hit = i;
              break;
            end
          end
          if (hit >= list_len) begin
            o.status = iale_pkg::ST_NOTFOUND;
          end else if (r.req_type == iale_pkg::OP_FIND) begin
            o.result_index = hit[iale_pkg::IDX_W-1:0];
          end else if (r.req_type == iale_pkg::OP_PRED) begin
            if (hit == 0) o.status = iale_pkg::ST_NONEIGH;
            else o.result_value = list_words[hit-1];
          end else begin
            if (hit + 1 >= list_len) o.status = iale_pkg::ST_NONEIGH;
            else o.result_value = list_words[hit+1];
          end
        end
      end
      iale_pkg::OP_CLEAR: list_len = 0;
      default: ;
    endcase
    o.list_length = list_len[iale_pkg::LEN_W-1:0];
    return o;
  endfunction

  task automatic queue_request(input logic [iale_pkg::OP_W-1:0] op, input int unsigned pos,
                               input logic signed [iale_pkg::DATA_W-1:0] val);
    iale_pkg::req_t r;
    r.req_type   = op;
    r.position   = pos[iale_pkg::POS_W-1:0];
    r.data_value = val;
    pending.push_back(r);
    // track the length only, so positions can be aimed at live entries
    case (op)
      iale_pkg::OP_INSERT:
        if (pos <= planned_len && planned_len < LIST_CAPACITY) planned_len++;
      iale_pkg::OP_DELETE: if (pos < planned_len) planned_len--;
      iale_pkg::OP_CLEAR:  planned_len = 0;
      default: ;
    endcase
  endtask

  // Mostly values from a small pool, so searches hit and duplicates appear.
  function automatic logic signed [iale_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  function automatic int unsigned pick_position(input bit for_insert);
    if ($urandom_range(0, 99) < 15) return $urandom_range(0, LIST_CAPACITY);
    if (for_insert) return $urandom_range(0, planned_len);
    if (planned_len == 0) return $urandom_range(0, LIST_CAPACITY);
    return $urandom_range(0, planned_len - 1);
  endfunction

  task automatic plan_random_request(input int bias);
    int r;
    int ins_w;
    int del_w;
    logic [iale_pkg::OP_W-1:0] op;
    ins_w = (bias == 2) ? 60 : (bias == 1) ? 30 : 10;
    del_w = (bias == 2) ? 10 : (bias == 1) ? 25 : 55;
    r = $urandom_range(0, 99);
    if (r == 0) begin
      op = iale_pkg::OP_CLEAR;
    end else if (r == 1) begin
      op = OP_UNUSED;
    end else if (r < 2 + ins_w) begin
      op = iale_pkg::OP_INSERT;
    end else if (r < 2 + ins_w + del_w) begin
      op = iale_pkg::OP_DELETE;
    end else begin
      case ($urandom_range(0, 3))
        0: op = iale_pkg::OP_READ;
        1: op = iale_pkg::OP_FIND;
        2: op = iale_pkg::OP_PRED;
        default: op = iale_pkg::OP_SUCC;
      endcase
    end
    queue_request(op, pick_position(op == iale_pkg::OP_INSERT), pick_value());
  endtask

  task automatic plan_full_list();
    while (planned_len < LIST_CAPACITY)
      queue_request(iale_pkg::OP_INSERT, $urandom_range(0, planned_len), pick_value());
    queue_request(iale_pkg::OP_INSERT, LIST_CAPACITY, pick_value());
    queue_request(iale_pkg::OP_INSERT, 0, pick_value());
    queue_request(iale_pkg::OP_READ, LIST_CAPACITY - 1, 0);
    queue_request(iale_pkg::OP_READ, LIST_CAPACITY, 0);
    queue_request(iale_pkg::OP_FIND, 0, value_pool[$urandom_range(0, 15)]);
    queue_request(iale_pkg::OP_PRED, 0, value_pool[$urandom_range(0, 15)]);
    queue_request(iale_pkg::OP_SUCC, 0, value_pool[$urandom_range(0, 15)]);
    queue_request(iale_pkg::OP_DELETE, LIST_CAPACITY - 1, 0);
    queue_request(iale_pkg::OP_DELETE, 0, 0);
  endtask

  task automatic plan_directed();
    // empty list: every access reports empty, insert past end is out of range
    queue_request(iale_pkg::OP_READ, 0, 0);
    queue_request(iale_pkg::OP_DELETE, 0, 0);
    queue_request(iale_pkg::OP_FIND, 0, 0);
    queue_request(iale_pkg::OP_PRED, 0, 0);
    queue_request(iale_pkg::OP_SUCC, 0, 0);
    queue_request(iale_pkg::OP_INSERT, 1, 5);
    // build [0, -1, min, max, -1, 7] by push, unshift and middle inserts
    queue_request(iale_pkg::OP_INSERT, 0, 32'sh8000_0000);
    queue_request(iale_pkg::OP_INSERT, 1, 32'sh7fff_ffff);
    queue_request(iale_pkg::OP_INSERT, 0, 0);
    queue_request(iale_pkg::OP_INSERT, 1, -1);
    queue_request(iale_pkg::OP_INSERT, 4, -1);
    queue_request(iale_pkg::OP_INSERT, 5, 7);
    queue_request(iale_pkg::OP_READ, 4, 0);
    queue_request(iale_pkg::OP_READ, LIST_CAPACITY, 0);
    queue_request(iale_pkg::OP_DELETE, 6, 0);
    queue_request(iale_pkg::OP_FIND, 0, -1);
    queue_request(iale_pkg::OP_FIND, 0, 12345);
    queue_request(iale_pkg::OP_PRED, 0, 0);
    queue_request(iale_pkg::OP_SUCC, 0, 7);
    queue_request(iale_pkg::OP_SUCC, 0, -1);
    queue_request(iale_pkg::OP_PRED, 0, 32'sh7fff_ffff);
    queue_request(iale_pkg::OP_PRED, 0, 99);
    queue_request(OP_UNUSED, 9'h155, 32'sh5a5a_a5a5);
    queue_request(iale_pkg::OP_DELETE, 0, 0);
    queue_request(iale_pkg::OP_DELETE, 4, 0);
    queue_request(iale_pkg::OP_CLEAR, 0, 0);
    queue_request(iale_pkg::OP_READ, 0, 0);
  endtask

  initial begin
    int bias;
    value_pool[0] = 0;
    value_pool[1] = -1;
    value_pool[2] = 1;
    value_pool[3] = 32'sh8000_0000;
    value_pool[4] = 32'sh7fff_ffff;
    for (int i = 5; i < 16; i++) value_pool[i] = $urandom;
    plan_directed();
    bias = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) bias = $urandom_range(0, 2);
      if (n == RANDOM_ITEMS / 2) plan_full_list();
      plan_random_request(bias);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Request driver: hold the payload while stalled, idle in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && !req_stall)
        expected_rsps.push_back(apply_list_request(req_data));
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          req_data  <= pending.pop_front();
          req_valid <= 1'b1;
          if (pending.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 15);
        end else begin
          req_valid <= 1'b0;
        end
      end
      tail_phase <= (pending.size() < TAIL_ITEMS);
    end
  end

  task automatic check_response(input iale_pkg::rsp_t got);
    iale_pkg::rsp_t want;
    checked_count++;
    if (expected_rsps.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("unexpected response: status %0d value %0d index %0d length %0d",
                 got.status, got.result_value, got.result_index, got.list_length);
      return;
    end
    want = expected_rsps.pop_front();
    if (got.status !== want.status || got.result_value !== want.result_value ||
        got.result_index !== want.result_index ||
        got.list_length !== want.list_length) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display({"response %0d mismatch: expected status %0d value %0d index %0d ",
                  "length %0d, got status %0d value %0d index %0d length %0d"},
                 checked_count, want.status, want.result_value, want.result_index,
                 want.list_length, got.status, got.result_value, got.result_index,
                 got.list_length);
    end
  endtask

  // Response monitor: check, then stall in random bursts; once, hold off long.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) check_response(rsp_data);
      if (backlog_hold > 0) begin
        backlog_hold--;
        rsp_stall <= 1'b1;
      end else if (!backlog_done && checked_count >= 300) begin
        backlog_done = 1'b1;
        backlog_hold = BACKLOG_CYCLES - 1;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        stuck = 0;
      else
        stuck++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: indexed_array_list_engine_top.f
+incdir+src
src/iale_pkg.sv
src/iale_cell.sv
src/iale_tree.sv
src/indexed_array_list_engine_top.sv
test/tb_indexed_array_list_engine_top.sv
